@@ rtl/core/bisn_pkg.sv @@
// Shared types, constants and the edge-fold function of the bordered image store.
package bisn_pkg;

    // Field and storage widths
    localparam int PIXEL_BITS     = 16;
    localparam int SIZE_BITS      = 7;
    localparam int COORD_BITS     = 8;
    localparam int FOLD_BITS      = 10;
    localparam int ACT_BITS       = 2;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 7;
    localparam int EDGE_BITS      = 2;
    localparam int SCALED_BITS    = 8;
    localparam int DIFF_BITS      = PIXEL_BITS + 1;
    localparam int DEN_BITS       = DIFF_BITS;
    localparam int NUM_BITS       = DEN_BITS + SCALED_BITS;
    localparam int PROD_BITS      = NUM_BITS + 1;

    // Defaults for the frame geometry
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int RESET_WIDTH    = 64;
    localparam int RESET_HEIGHT   = 64;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_BREAD   = 2'd1,
        ACT_MEASURE = 2'd2,
        ACT_SREAD   = 2'd3
    } t_action;

    typedef enum logic [EDGE_BITS-1:0] {
        EDGE_BLACK  = 2'd0,
        EDGE_REPEAT = 2'd1,
        EDGE_MIRROR = 2'd2,
        EDGE_WRAP   = 2'd3
    } t_edge;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_EDGE_MODE    = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_RDATA,
        S_PREP,
        S_DIVIDE,
        S_EMIT,
        S_SCAN,
        S_SCAN_END
    } t_state;

    // Request to and response from the serial divider
    typedef struct packed {
        logic                start;
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [SCALED_BITS-1:0] quot;
    } t_div_rsp;

    // Fold one axis back into 0..n-1 by the edge rule, then clamp
    function automatic logic [SIZE_BITS-1:0] fold_axis(
        input logic signed [FOLD_BITS-1:0] c,
        input logic        [SIZE_BITS-1:0] n,
        input t_edge                       mode
    );
        logic signed [FOLD_BITS-1:0] v;
        logic signed [FOLD_BITS-1:0] ns;
        logic signed [FOLD_BITS-1:0] one;
        ns  = signed'(FOLD_BITS'(n));
        one = signed'(FOLD_BITS'(1));
        v   = c;
        if (mode == EDGE_MIRROR) begin
            if (v[FOLD_BITS-1]) v = -v;
            if (v >= ns) v = ns + ns - v - one;
        end else if (mode == EDGE_WRAP) begin
            if (v[FOLD_BITS-1]) v = ns + v;
            if (v >= ns) v = v - ns;
        end
        if (v[FOLD_BITS-1]) begin
            v = '0;
        end else if (v >= ns) begin
            v = ns - one;
        end
        return v[SIZE_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/bisn_if.sv @@
// Handshake channels of the bordered image store: input, result and configuration.
interface bisn_in_if import bisn_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [ACT_BITS-1:0]          action;
    logic signed [COORD_BITS-1:0] col;
    logic signed [COORD_BITS-1:0] row;
    logic signed [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, action, col, row, pixel_in, input ready);
    modport sink   (input valid, action, col, row, pixel_in, output ready);
endinterface

interface bisn_out_if import bisn_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_out;
    logic [SCALED_BITS-1:0]       scaled_out;

    modport source (output valid, pixel_out, scaled_out, input ready);
    modport sink   (input valid, pixel_out, scaled_out, output ready);
endinterface

interface bisn_cfg_if import bisn_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/bisn_div.sv @@
// Restoring serial divider: one trial subtract a cycle, quotient saturated to 0..255.
module bisn_div import bisn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_BITS = $clog2(SCALED_BITS + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [STEP_BITS-1:0]   r_step;
    logic [NUM_BITS-1:0]    r_rem;
    logic [NUM_BITS-1:0]    r_dsh;
    logic [SCALED_BITS-1:0] r_quot;
    logic [NUM_BITS:0]      trial;
    logic                   fits;

    // Trial subtract of the shifted divisor
    assign trial = {1'b0, r_rem} - {1'b0, r_dsh};
    assign fits  = !trial[NUM_BITS];

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_BITS'(SCALED_BITS);
            end else if (r_busy) begin
                // first step checks for a quotient past the 8-bit range
                if ((r_step == STEP_BITS'(SCALED_BITS) && fits) || r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step - STEP_BITS'(1);
            end
        end
    end

    // Datapath: remainder, shifted divisor, quotient bits
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_dsh  <= {i_req.den, {SCALED_BITS{1'b0}}};
            r_quot <= '0;
        end else if (r_busy) begin
            if (fits) r_rem <= trial[NUM_BITS-1:0];
            if (r_step == STEP_BITS'(SCALED_BITS)) begin
                if (fits) r_quot <= '1;
            end else begin
                r_quot <= {r_quot[SCALED_BITS-2:0], fits};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

@@ rtl/core/bordered_image_store_with_normalize_core.sv @@
// Top level: frame store with edge-rule reads, range measure and scaled reads.
//
// Channels: i_in takes one command word (action, col, row, pixel_in); o_out gives
// one result word (pixel_out, scaled_out) for bordered and scaled reads, none for
// writes and measures; i_cfg writes frame_width (0), frame_height (1), edge_mode (2)
// and is always ready. Configure only while the block is idle.
// From acceptance back to ready: a write passes S_ADDR; a bordered read S_ADDR, S_RDATA,
// S_EMIT; a scaled read adds S_PREP, straight to S_EMIT when the quotient is trivially 0,
// else S_DIVIDE, where the serial divider resolves one quotient bit a cycle and stops after
// its first step when the quotient saturates at 255. A read waits in S_EMIT for the output
// register to free. A measure reads one pixel a cycle through the single store read port.
// Reset: configuration returns to 64 x 64, repeat edges, range 0..0; the store is
// then swept to zero at one entry a cycle over all MAX_WIDTH*MAX_HEIGHT entries (4096 by
// default), and i_in stays not ready until the sweep ends.
// Results sit in an output register; while the receiver stalls the block still
// takes the next word and holds its own result until the register frees.
module bordered_image_store_with_normalize_core import bisn_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bisn_in_if.sink     i_in,
    bisn_out_if.source  o_out,
    bisn_cfg_if.sink    i_cfg
);

    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int A_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int SUM_BITS = (CNT_BITS > 2 * SIZE_BITS + 1) ? CNT_BITS : 2 * SIZE_BITS + 1;

    t_state r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;

    // configuration
    logic [SIZE_BITS-1:0] r_cfg_w, r_cfg_h;
    t_edge                r_edge;
    logic [SIZE_BITS-1:0] w_eff, h_eff;

    // latched command word
    t_action                      r_act;
    logic signed [COORD_BITS-1:0] r_col, r_row;
    logic signed [PIXEL_BITS-1:0] r_pix;

    // address path
    logic signed [FOLD_BITS-1:0] c_ext, r_ext, w_ext, h_ext;
    logic                        in_frame;
    logic [SIZE_BITS-1:0]        fc, fr;
    logic [SUM_BITS-1:0]         addr_sum, area_m1;
    logic [A_BITS-1:0]           addr;
    logic [CNT_BITS-1:0]         last_idx;

    // store
    logic [PIXEL_BITS-1:0] r_mem [DEPTH];
    logic [PIXEL_BITS-1:0] r_rdata;
    logic                  mem_we;
    logic [A_BITS-1:0]     mem_waddr, mem_raddr;
    logic [PIXEL_BITS-1:0] mem_wdata;

    // range and scaling
    logic signed [PIXEL_BITS-1:0] r_min, r_max;
    logic                         r_sv, r_sfirst;
    logic                         r_zero;
    logic signed [PIXEL_BITS-1:0] r_p, p_sel;
    logic signed [DIFF_BITS-1:0]  r_diff, r_den, dd;
    logic signed [PROD_BITS-1:0]  num;
    logic [PROD_BITS-1:0]         num_mag;
    logic [DIFF_BITS-1:0]         den_mag;
    logic                         zero_q;
    logic [SCALED_BITS-1:0]       r_scaled;
    logic                         div_start;
    t_div_req                     div_req;
    t_div_rsp                     div_rsp;

    // output register
    logic                         r_ovalid;
    logic signed [PIXEL_BITS-1:0] r_opix;
    logic [SCALED_BITS-1:0]       r_oscaled;
    logic                         out_load;

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= SIZE_BITS'(RESET_WIDTH);
            r_cfg_h <= SIZE_BITS'(RESET_HEIGHT);
            r_edge  <= EDGE_REPEAT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg.data;
                CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg.data;
                CFG_EDGE_MODE:    r_edge  <= t_edge'(i_cfg.data[EDGE_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, oversize as the maximum
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = SIZE_BITS'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = SIZE_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = SIZE_BITS'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = SIZE_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_h;
        end
    end

    // Latch the command word on acceptance
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_act <= t_action'(i_in.action);
            r_col <= i_in.col;
            r_row <= i_in.row;
            r_pix <= i_in.pixel_in;
        end
    end

    // Fold coordinates and form the linear address col + row * width
    assign c_ext    = FOLD_BITS'(r_col);
    assign r_ext    = FOLD_BITS'(r_row);
    assign w_ext    = signed'(FOLD_BITS'(w_eff));
    assign h_ext    = signed'(FOLD_BITS'(h_eff));
    assign in_frame = !c_ext[FOLD_BITS-1] && (c_ext < w_ext)
                   && !r_ext[FOLD_BITS-1] && (r_ext < h_ext);
    assign fc       = fold_axis(c_ext, w_eff, r_edge);
    assign fr       = fold_axis(r_ext, h_eff, r_edge);
    assign addr_sum = SUM_BITS'(fc) + SUM_BITS'(fr) * SUM_BITS'(w_eff);
    assign addr     = addr_sum[A_BITS-1:0];
    assign area_m1  = SUM_BITS'(w_eff) * SUM_BITS'(h_eff) - SUM_BITS'(1);
    assign last_idx = area_m1[CNT_BITS-1:0];

    // Store ports: the clearing sweep or a write, and one registered read
    assign mem_we    = (r_state == S_CLEAR)
                    || (r_state == S_ADDR && r_act == ACT_WRITE && in_frame);
    assign mem_waddr = (r_state == S_CLEAR) ? r_cnt[A_BITS-1:0] : addr;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : r_pix;
    assign mem_raddr = (r_state == S_SCAN) ? r_cnt[A_BITS-1:0] : addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and handshake
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        i_in.ready     = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) n_state = S_ADDR;
            end
            S_ADDR: begin
                case (r_act)
                    ACT_WRITE: n_state = S_IDLE;
                    ACT_MEASURE: begin
                        n_cnt   = '0;
                        n_state = S_SCAN;
                    end
                    default: n_state = S_RDATA;
                endcase
            end
            S_RDATA: begin
                n_state = (r_act == ACT_SREAD) ? S_PREP : S_EMIT;
            end
            S_PREP: begin
                if (zero_q) begin
                    n_state = S_EMIT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (div_rsp.done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + CNT_BITS'(1);
                if (r_cnt == last_idx) n_state = S_SCAN_END;
            end
            S_SCAN_END: begin
                n_cnt   = '0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Range scan: the registered read data arrives in the cycle after its address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv     <= 1'b0;
            r_sfirst <= 1'b0;
            r_min    <= '0;
            r_max    <= '0;
        end else begin
            r_sv     <= (r_state == S_SCAN);
            r_sfirst <= (r_state == S_SCAN) && (r_cnt == '0);
            if (r_sv) begin
                if (r_sfirst) begin
                    r_min <= signed'(r_rdata);
                    r_max <= signed'(r_rdata);
                end else begin
                    if (signed'(r_rdata) < r_min) r_min <= signed'(r_rdata);
                    if (signed'(r_rdata) > r_max) r_max <= signed'(r_rdata);
                end
            end
        end
    end

    // Pixel pick and scaling operands
    assign p_sel = r_zero ? '0 : signed'(r_rdata);
    assign dd    = DIFF_BITS'(r_max) - DIFF_BITS'(r_min);

    // (p - min) * 255 as a shift and subtract
    assign num     = (PROD_BITS'(r_diff) <<< SCALED_BITS) - PROD_BITS'(r_diff);
    assign num_mag = num[PROD_BITS-1] ? PROD_BITS'(-num) : PROD_BITS'(num);
    assign den_mag = r_den[DIFF_BITS-1] ? DIFF_BITS'(-r_den) : DIFF_BITS'(r_den);
    // floor of a negative or zero ratio saturates to 0
    assign zero_q  = (num == '0) || (r_den == '0)
                  || (num[PROD_BITS-1] != r_den[DIFF_BITS-1]);

    assign div_req = {div_start, num_mag[NUM_BITS-1:0], den_mag};

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADDR) begin
            r_zero <= !in_frame && (r_edge == EDGE_BLACK);
        end
        if (r_state == S_RDATA) begin
            r_p      <= p_sel;
            r_diff   <= DIFF_BITS'(p_sel) - DIFF_BITS'(r_min);
            r_den    <= (dd == '0) ? DIFF_BITS'(r_max) : dd;
            r_scaled <= '0;
        end
        if (r_state == S_DIVIDE && div_rsp.done) begin
            r_scaled <= div_rsp.quot;
        end
    end

    bisn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Output register: load a finished word, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_opix    <= r_p;
            r_oscaled <= (r_act == ACT_SREAD) ? r_scaled : '0;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.pixel_out  = r_opix;
    assign o_out.scaled_out = r_oscaled;

    // Checks
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_END) |=> (r_min <= r_max))
        else $error("measured minimum above maximum");

    a_div_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIVIDE))
        else $error("divider finished outside the divide state");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == S_EMIT))
        else $error("result word raised outside the emit state");

    a_bread_unscaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_act == ACT_BREAD) |-> (r_scaled == '0))
        else $error("bordered read carries a scaled value");

endmodule

@@ verif/bisn_frame_checker.sv @@
// Channel monitor for the bordered image store: mirrors the frame and checks every read word.
`timescale 1ns / 1ps
module bisn_frame_checker import bisn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bisn_in_if   i_cmd,
    bisn_out_if  i_res,
    bisn_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam int MAX_W          = DEF_MAX_WIDTH;
    localparam int MAX_H          = DEF_MAX_HEIGHT;
    localparam int STORE_DEPTH    = MAX_W * MAX_H;
    localparam int SHOWN_MISMATCH = 10;
    localparam int SCALE_TOP      = 255;

    typedef struct {
        logic signed [PIXEL_BITS-1:0] pixel;
        logic [SCALED_BITS-1:0]       scaled;
    } t_read_word;

    // Mirror of the block's state and registers
    logic signed [PIXEL_BITS-1:0] frame_copy [STORE_DEPTH];
    logic signed [PIXEL_BITS-1:0] range_lo;
    logic signed [PIXEL_BITS-1:0] range_hi;
    logic [SIZE_BITS-1:0]         width_reg;
    logic [SIZE_BITS-1:0]         height_reg;
    t_edge                        edge_reg;
    t_read_word                   pending_reads[$];

    // Size register as the block uses it: zero acts as one, overlarge as the maximum
    function automatic int used_size(input logic [SIZE_BITS-1:0] v, input int maxv);
        if (v == '0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    // Fold one axis back into the frame, then clamp whatever is still outside
    function automatic int fold_coord(input int c, input int n, input t_edge mode);
        int v;
        v = c;
        if (mode == EDGE_MIRROR) begin
            if (v < 0) v = -v;
            if (v >= n) v = 2 * n - v - 1;
        end else if (mode == EDGE_WRAP) begin
            if (v < 0) v = n + v;
            if (v >= n) v = v - n;
        end
        if (v < 0) v = 0;
        else if (v >= n) v = n - 1;
        return v;
    endfunction

    function automatic logic signed [PIXEL_BITS-1:0] stored_pixel(input int c, input int r,
                                                                  input int w);
        int a;
        a = c + r * w;
        if (a < 0 || a >= STORE_DEPTH) return '0;
        return frame_copy[a];
    endfunction

    function automatic logic signed [PIXEL_BITS-1:0] bordered_pixel(input int c, input int r,
                                                                    input int w, input int h);
        if (c >= 0 && c < w && r >= 0 && r < h) return stored_pixel(c, r, w);
        if (edge_reg == EDGE_BLACK) return '0;
        return stored_pixel(fold_coord(c, w, edge_reg), fold_coord(r, h, edge_reg), w);
    endfunction

    // Floor of (p - min) * 255 / span, saturated; span falls back to max, zero gives zero
    function automatic logic [SCALED_BITS-1:0] scaled_pixel(
        input logic signed [PIXEL_BITS-1:0] p
    );
        longint span;
        longint num;
        longint q;
        span = longint'(range_hi) - longint'(range_lo);
        if (span == 0) span = longint'(range_hi);
        if (span == 0) return '0;
        num = (longint'(p) - longint'(range_lo)) * SCALE_TOP;
        q   = num / span;
        if ((num % span) != 0 && ((num < 0) != (span < 0))) q--;
        if (q < 0) q = 0;
        if (q > SCALE_TOP) q = SCALE_TOP;
        return SCALED_BITS'(q);
    endfunction

    task automatic measure_range(input int n);
        logic signed [PIXEL_BITS-1:0] lo;
        logic signed [PIXEL_BITS-1:0] hi;
        lo = frame_copy[0];
        hi = lo;
        if (n > STORE_DEPTH) n = STORE_DEPTH;
        for (int i = 1; i < n; i++) begin
            if (frame_copy[i] < lo) lo = frame_copy[i];
            if (frame_copy[i] > hi) hi = frame_copy[i];
        end
        range_lo = lo;
        range_hi = hi;
    endtask

    task automatic note_mismatch(input string msg);
        if (o_fail_count < SHOWN_MISMATCH) $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_read_word got;
        t_read_word want;
        int         w;
        int         h;
        int         c;
        int         r;
        int         a;
        if (!i_rst_n) begin
            foreach (frame_copy[i]) frame_copy[i] = '0;
            range_lo     = '0;
            range_hi     = '0;
            width_reg    = SIZE_BITS'(RESET_WIDTH);
            height_reg   = SIZE_BITS'(RESET_HEIGHT);
            edge_reg     = EDGE_REPEAT;
            o_fail_count = 0;
            o_checked    = 0;
            pending_reads.delete();
        end else begin
            // Compare a result word with the oldest expectation
            if (i_res.valid && i_res.ready) begin
                got.pixel  = i_res.pixel_out;
                got.scaled = i_res.scaled_out;
                if (pending_reads.size() == 0) begin
                    note_mismatch($sformatf("result word with nothing expected: pixel %0d scaled %0d",
                                            got.pixel, got.scaled));
                end else begin
                    want = pending_reads.pop_front();
                    o_checked++;
                    if (got.pixel !== want.pixel)
                        note_mismatch($sformatf("pixel_out expected %0d, got %0d",
                                                want.pixel, got.pixel));
                    if (got.scaled !== want.scaled)
                        note_mismatch($sformatf("scaled_out expected %0d, got %0d (pixel %0d)",
                                                want.scaled, got.scaled, want.pixel));
                end
            end

            // Advance the mirror on an accepted command word
            if (i_cmd.valid && i_cmd.ready) begin
                w = used_size(width_reg, MAX_W);
                h = used_size(height_reg, MAX_H);
                c = int'(i_cmd.col);
                r = int'(i_cmd.row);
                case (t_action'(i_cmd.action))
                    ACT_WRITE: begin
                        if (c >= 0 && c < w && r >= 0 && r < h) begin
                            a = c + r * w;
                            if (a < STORE_DEPTH) frame_copy[a] = i_cmd.pixel_in;
                        end
                    end
                    ACT_MEASURE: measure_range(w * h);
                    default: begin
                        want.pixel  = bordered_pixel(c, r, w, h);
                        want.scaled = (t_action'(i_cmd.action) == ACT_SREAD) ?
                                      scaled_pixel(want.pixel) : '0;
                        pending_reads.push_back(want);
                    end
                endcase
            end

            // Track register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_FRAME_WIDTH:  width_reg  = i_cfg.data[SIZE_BITS-1:0];
                    CFG_FRAME_HEIGHT: height_reg = i_cfg.data[SIZE_BITS-1:0];
                    CFG_EDGE_MODE:    edge_reg   = t_edge'(i_cfg.data[EDGE_BITS-1:0]);
                    default: ;
                endcase
            end
        end
        o_pending = pending_reads.size();
    end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the bordered image store: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps
module tb_top;
    import bisn_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 1400;
    localparam int CALM_WORDS   = 150;
    localparam int DRAIN_CYCLES = DEF_MAX_WIDTH * DEF_MAX_HEIGHT + 100;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int COORD_LO     = -64;
    localparam int COORD_HI     = 127;
    localparam int PIX_MIN      = -32768;
    localparam int PIX_MAX      = 32767;
    localparam int FILL_MAX     = 24;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    int   fail_count;
    int   pending;
    int   checked;
    bit   calm = 1'b0;
    bit   hold_wanted = 1'b0;
    int   cur_w = RESET_WIDTH;
    int   cur_h = RESET_HEIGHT;
    int   words_sent = 0;
    int   n_write = 0;
    int   n_bread = 0;
    int   n_sread = 0;
    int   n_measure = 0;
    int   n_settings = 0;

    bisn_in_if  cmd_ch ();
    bisn_out_if res_ch ();
    bisn_cfg_if cfg_ch ();

    bordered_image_store_with_normalize_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    bisn_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads outstanding", cycle_count, pending);
            $display("FAIL bordered_image_store_with_normalize_core");
            $finish;
        end
    end

    // Coordinate mostly within a frame's width of the edges, sometimes anywhere
    function automatic int coord_near(input int n);
        int v;
        if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, COORD_HI - COORD_LO)) + COORD_LO;
        v = int'($urandom_range(0, 3 * n - 1)) - n;
        return (v < COORD_LO) ? COORD_LO : (v > COORD_HI) ? COORD_HI : v;
    endfunction

    function automatic int pixel_value();
        case ($urandom_range(0, 9))
            0:       return PIX_MIN;
            1:       return PIX_MAX;
            2, 3:    return int'($urandom_range(0, 65535)) + PIX_MIN;
            default: return int'($urandom_range(0, 600)) - 300;
        endcase
    endfunction

    // Offer one command word, hold it until taken, then maybe pause
    task automatic send_word(input t_action act, input int c, input int r, input int pix);
        cmd_ch.valid    <= 1'b1;
        cmd_ch.action   <= act;
        cmd_ch.col      <= c[COORD_BITS-1:0];
        cmd_ch.row      <= r[COORD_BITS-1:0];
        cmd_ch.pixel_in <= pix[PIXEL_BITS-1:0];
        do @(posedge i_clk); while (!cmd_ch.ready);
        words_sent++;
        case (act)
            ACT_WRITE:   n_write++;
            ACT_BREAD:   n_bread++;
            ACT_SREAD:   n_sread++;
            ACT_MEASURE: n_measure++;
            default: ;
        endcase
        if (!calm && $urandom_range(0, 7) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every read word, then let a full-frame measure finish
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_word(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] d);
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic set_frame(input int fw, input int fh, input t_edge mode);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_word(CFG_FRAME_WIDTH, fw[CFG_DATA_BITS-1:0]);
        cfg_word(CFG_FRAME_HEIGHT, fh[CFG_DATA_BITS-1:0]);
        cfg_word(CFG_EDGE_MODE, CFG_DATA_BITS'(mode));
        cfg_ch.valid <= 1'b0;
        cur_w = (fw < 1) ? 1 : (fw > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : fw;
        cur_h = (fh < 1) ? 1 : (fh > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : fh;
        n_settings++;
    endtask

    // Result receiver: random stalls, one long hold-off on request, none at the end
    initial begin : receiver
        res_ch.ready = 1'b0;
        forever begin
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int fw;
        int fh;
        int fill;
        int body;
        int pick;
        int phase;
        int directed_words;
        cmd_ch.valid    = 1'b0;
        cmd_ch.action   = ACT_WRITE;
        cmd_ch.col      = '0;
        cmd_ch.row      = '0;
        cmd_ch.pixel_in = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_FRAME_WIDTH;
        cfg_ch.data     = '0;
        i_rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry 64 x 64, repeat edges, range 0..0: zero divisor first
        send_word(ACT_SREAD, 0, 0, 0);
        send_word(ACT_WRITE, 0, 0, PIX_MAX);
        send_word(ACT_WRITE, 63, 63, PIX_MIN);
        send_word(ACT_WRITE, 64, 0, 1234);
        send_word(ACT_WRITE, -1, 5, 1234);
        send_word(ACT_BREAD, COORD_LO, COORD_LO, 0);
        send_word(ACT_BREAD, COORD_HI, COORD_HI, 0);
        send_word(ACT_MEASURE, 0, 0, 0);
        send_word(ACT_SREAD, 63, 63, 0);
        send_word(ACT_SREAD, 0, 0, 0);
        send_word(ACT_SREAD, 5, 5, 0);

        // Size registers out of range: zero acts as one, 127 as the maximum
        set_frame(0, COORD_HI, EDGE_MIRROR);
        send_word(ACT_WRITE, 0, 2, 5);
        send_word(ACT_BREAD, -3, 2, 0);
        send_word(ACT_BREAD, 0, COORD_HI, 0);
        send_word(ACT_BREAD, 0, COORD_LO, 0);

        // One-pixel frame: flat negative range, then a stale range
        set_frame(1, 1, EDGE_WRAP);
        send_word(ACT_WRITE, 0, 0, -7);
        send_word(ACT_MEASURE, 0, 0, 0);
        send_word(ACT_SREAD, 0, 0, 0);
        send_word(ACT_WRITE, 0, 0, 100);
        send_word(ACT_SREAD, 0, -1, 0);

        set_frame(DEF_MAX_WIDTH, DEF_MAX_HEIGHT, EDGE_BLACK);
        send_word(ACT_BREAD, -1, 0, 0);
        send_word(ACT_BREAD, 64, 5, 0);
        send_word(ACT_BREAD, 10, 10, 0);
        directed_words = words_sent;

        // Random phases: fill, measure, then a mix of reads and writes around the frame
        phase = 0;
        while (words_sent - directed_words < RANDOM_WORDS) begin
            case ($urandom_range(0, 4))
                0: begin
                    fw = $urandom_range(0, 127);
                    fh = $urandom_range(0, 127);
                end
                1: begin
                    fw = $urandom_range(9, DEF_MAX_WIDTH);
                    fh = $urandom_range(1, 16);
                end
                default: begin
                    fw = $urandom_range(1, 8);
                    fh = $urandom_range(1, 8);
                end
            endcase
            set_frame(fw, fh, t_edge'(phase % 4));
            if (phase == 1) hold_wanted = 1'b1;
            fill = (cur_w * cur_h < FILL_MAX) ? cur_w * cur_h : FILL_MAX;
            repeat (fill)
                send_word(ACT_WRITE, $urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                          pixel_value());
            send_word(ACT_MEASURE, coord_near(cur_w), coord_near(cur_h), pixel_value());
            body = $urandom_range(80, 160);
            for (int k = 0; k < body && words_sent - directed_words < RANDOM_WORDS; k++) begin
                calm = (words_sent - directed_words >= RANDOM_WORDS - CALM_WORDS);
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    send_word(ACT_WRITE, $urandom_range(0, cur_w - 1),
                              $urandom_range(0, cur_h - 1), pixel_value());
                else if (pick < 35)
                    send_word(ACT_WRITE, coord_near(cur_w), coord_near(cur_h), pixel_value());
                else if (pick < 63)
                    send_word(ACT_BREAD, coord_near(cur_w), coord_near(cur_h), pixel_value());
                else if (pick < 96)
                    send_word(ACT_SREAD, coord_near(cur_w), coord_near(cur_h), pixel_value());
                else
                    send_word(ACT_MEASURE, coord_near(cur_w), coord_near(cur_h), pixel_value());
            end
            phase++;
        end

        settle();
        $display("Sent %0d writes, %0d bordered reads, %0d scaled reads, %0d range measures",
                 n_write, n_bread, n_sread, n_measure);
        $display("across %0d frame settings and all four edge rules; %0d read words checked",
                 n_settings, checked);
        if (fail_count == 0)
            $display("PASS bordered_image_store_with_normalize_core");
        else
            $display("FAIL bordered_image_store_with_normalize_core");
        $finish;
    end

endmodule
